@@ design/ccd_pkg.sv @@
// ----------------------------------------------------------------------------
// ccd_pkg: shared types and constants of the coin change dispenser
// Field widths, coin value and reciprocal tables, command codes, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ccd_pkg;

   // Field widths
   localparam int COUNT_BITS_DEFAULT = 10;
   localparam int NUM_SLOTS          = 6;
   localparam int SLOT_BITS          = 3;
   localparam int CMD_BITS           = 2;
   localparam int AMOUNT_BITS        = 10;
   localparam int DUE_BITS           = 16;
   localparam int PAID_BITS          = 10;
   localparam int BAL_BITS           = 19;
   localparam int VALUE_BITS         = 8;

   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(NUM_SLOTS - 1);

   // Reciprocals for divide-by-coin-value: floor(2^32 / value)
   localparam int RECIP_SHIFT = 32;
   localparam int RECIP_BITS  = 30;
   localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SHIFT;
   localparam logic [RECIP_BITS-1:0] RECIP_200 = RECIP_BITS'(RECIP_ONE / 200);
   localparam logic [RECIP_BITS-1:0] RECIP_100 = RECIP_BITS'(RECIP_ONE / 100);
   localparam logic [RECIP_BITS-1:0] RECIP_50  = RECIP_BITS'(RECIP_ONE / 50);
   localparam logic [RECIP_BITS-1:0] RECIP_20  = RECIP_BITS'(RECIP_ONE / 20);
   localparam logic [RECIP_BITS-1:0] RECIP_10  = RECIP_BITS'(RECIP_ONE / 10);
   localparam logic [RECIP_BITS-1:0] RECIP_5   = RECIP_BITS'(RECIP_ONE / 5);

   // Request command codes; any other code acts as a balance query
   typedef enum logic [CMD_BITS-1:0] {
      CMD_DEPOSIT = 2'd0,
      CMD_CHANGE  = 2'd1,
      CMD_QUERY   = 2'd2
   } cmd_code_type;

   // Result status codes
   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic dep_write;
      logic dep_add;
      logic div_mul;
      logic div_fix;
      logic div_take;
      logic commit;
      logic emit_pay;
      logic emit_single;
      logic single_fail;
   } ccd_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic last_slot;
      logic rem_zero;
   } ccd_status_type;

   // Coin value of a slot, largest first
   function automatic logic [VALUE_BITS-1:0] coin_value(input logic [SLOT_BITS-1:0] idx);
      logic [VALUE_BITS-1:0] val;
      case (idx)
         3'd0:    val = 8'd200;
         3'd1:    val = 8'd100;
         3'd2:    val = 8'd50;
         3'd3:    val = 8'd20;
         3'd4:    val = 8'd10;
         3'd5:    val = 8'd5;
         default: val = 8'd0;
      endcase
      return val;
   endfunction

   // Reciprocal of a slot's coin value
   function automatic logic [RECIP_BITS-1:0] coin_recip(input logic [SLOT_BITS-1:0] idx);
      logic [RECIP_BITS-1:0] rcp;
      case (idx)
         3'd0:    rcp = RECIP_200;
         3'd1:    rcp = RECIP_100;
         3'd2:    rcp = RECIP_50;
         3'd3:    rcp = RECIP_20;
         3'd4:    rcp = RECIP_10;
         3'd5:    rcp = RECIP_5;
         default: rcp = '0;
      endcase
      return rcp;
   endfunction

endpackage

`default_nettype wire

@@ design/ccd_datapath.sv @@
// ----------------------------------------------------------------------------
// ccd_datapath: coin counts, balance, greedy divide unit and result register
// Holds the per-slot counts and a running balance, works one slot per
// three commands through a reciprocal divide, and builds each result.
// ----------------------------------------------------------------------------
`default_nettype none

module ccd_datapath #(
   parameter int COUNT_BITS = ccd_pkg::COUNT_BITS_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire ccd_pkg::ccd_cmd_type            cmd,
   output ccd_pkg::ccd_status_type              status,
   input  wire [ccd_pkg::SLOT_BITS-1:0]         req_coin_slot,
   input  wire [ccd_pkg::AMOUNT_BITS-1:0]       req_coin_amount,
   input  wire [ccd_pkg::DUE_BITS-1:0]          req_change_due,
   output logic                                 rsp_status,
   output logic [ccd_pkg::SLOT_BITS-1:0]        rsp_paid_slot,
   output logic [ccd_pkg::PAID_BITS-1:0]        rsp_paid_count,
   output logic [ccd_pkg::BAL_BITS-1:0]         rsp_balance,
   output logic                                 rsp_last
);

   localparam int SLOT_W   = ccd_pkg::SLOT_BITS;
   localparam int DUE_W    = ccd_pkg::DUE_BITS;
   localparam int BAL_W    = ccd_pkg::BAL_BITS;
   localparam int PAID_W   = ccd_pkg::PAID_BITS;
   localparam int AMOUNT_W = ccd_pkg::AMOUNT_BITS;
   localparam int SUM_BITS = ((COUNT_BITS > AMOUNT_W) ? COUNT_BITS : AMOUNT_W) + 1;
   localparam int CPROD_BITS = COUNT_BITS + ccd_pkg::VALUE_BITS;
   localparam int MUL_BITS   = DUE_W + ccd_pkg::RECIP_BITS;
   localparam int CMP_BITS   = (COUNT_BITS > DUE_W) ? COUNT_BITS : DUE_W;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [SLOT_W-1:0]     SLOT_LIMIT = SLOT_W'(ccd_pkg::NUM_SLOTS);

   // State
   logic [COUNT_BITS-1:0] counts_ff [ccd_pkg::NUM_SLOTS];
   logic [COUNT_BITS-1:0] counts_in [ccd_pkg::NUM_SLOTS];
   logic [COUNT_BITS-1:0] take_ff   [ccd_pkg::NUM_SLOTS];
   logic [COUNT_BITS-1:0] take_in   [ccd_pkg::NUM_SLOTS];
   logic [BAL_W-1:0]      balance_ff, balance_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;

   // Per-request working registers
   logic [SLOT_W-1:0]     dslot_ff, dslot_in;
   logic [AMOUNT_W-1:0]   amount_ff, amount_in;
   logic [DUE_W-1:0]      due_ff, due_in;
   logic [DUE_W-1:0]      rem_ff, rem_in;
   logic [MUL_BITS-1:0]   mul_ff, mul_in;
   logic [DUE_W-1:0]      q0_ff, q0_in;
   logic [DUE_W-1:0]      r0_ff, r0_in;
   logic [CPROD_BITS-1:0] cprod_ff, cprod_in;
   logic [CPROD_BITS-1:0] dprod_ff, dprod_in;

   // Result register
   logic                  rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [PAID_W-1:0]     rsp_count_ff, rsp_count_in;
   logic [BAL_W-1:0]      rsp_balance_ff, rsp_balance_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Combinational helpers
   logic [SLOT_W-1:0]               rd_idx;
   logic                            slot_ok;
   logic [COUNT_BITS-1:0]           count_rd;
   logic [COUNT_BITS-1:0]           take_rd;
   logic [ccd_pkg::VALUE_BITS-1:0]  value_rd;
   logic [ccd_pkg::RECIP_BITS-1:0]  recip_rd;
   logic [SUM_BITS-1:0]             dep_sum;
   logic [COUNT_BITS-1:0]           dep_new;
   logic [COUNT_BITS-1:0]           dep_delta;
   logic [DUE_W-1:0]                q0_calc;
   logic [DUE_W-1:0]                q_fix;
   logic [DUE_W-1:0]                r_fix;
   logic                            use_count;

   // Shared read port of the count array: deposit slot or working slot
   always_comb begin
      rd_idx   = cmd.dep_write ? dslot_ff : slot_ff;
      slot_ok  = rd_idx < SLOT_LIMIT;
      count_rd = slot_ok ? counts_ff[rd_idx] : '0;
      take_rd  = take_ff[slot_ff];
      value_rd = ccd_pkg::coin_value(rd_idx);
      recip_rd = ccd_pkg::coin_recip(slot_ff);
   end

   // Deposit: saturating add, and the value added to the balance
   always_comb begin
      dep_sum   = SUM_BITS'(count_rd) + SUM_BITS'(amount_ff);
      dep_new   = (dep_sum > SUM_BITS'(COUNT_MAX)) ? COUNT_MAX : COUNT_BITS'(dep_sum);
      dep_delta = slot_ok ? (dep_new - count_rd) : '0;
   end

   // Divide fix-up: quotient estimate is low by at most one
   always_comb begin
      q0_calc   = DUE_W'(mul_ff >> ccd_pkg::RECIP_SHIFT);
      if (r0_ff >= DUE_W'(value_rd)) begin
         q_fix = q0_ff + 1'b1;
         r_fix = r0_ff - DUE_W'(value_rd);
      end else begin
         q_fix = q0_ff;
         r_fix = r0_ff;
      end
      use_count = CMP_BITS'(count_rd) < CMP_BITS'(q_fix);
   end

   // Next-state logic
   always_comb begin
      counts_in      = counts_ff;
      take_in        = take_ff;
      balance_in     = balance_ff;
      slot_in        = slot_ff;
      dslot_in       = dslot_ff;
      amount_in      = amount_ff;
      due_in         = due_ff;
      rem_in         = rem_ff;
      mul_in         = mul_ff;
      q0_in          = q0_ff;
      r0_in          = r0_ff;
      cprod_in       = cprod_ff;
      dprod_in       = dprod_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_balance_in = rsp_balance_ff;
      rsp_last_in    = rsp_last_ff;

      // latch the request
      if (cmd.load_req) begin
         dslot_in  = req_coin_slot;
         amount_in = req_coin_amount;
         due_in    = req_change_due;
         rem_in    = req_change_due;
         slot_in   = '0;
      end

      // deposit
      if (cmd.dep_write) begin
         if (slot_ok) begin
            counts_in[rd_idx] = dep_new;
         end
         dprod_in = CPROD_BITS'(dep_delta) * CPROD_BITS'(value_rd);
      end
      if (cmd.dep_add) begin
         balance_in = balance_ff + BAL_W'(dprod_ff);
      end

      // greedy pass, one slot per three steps
      if (cmd.div_mul) begin
         mul_in = MUL_BITS'(rem_ff) * MUL_BITS'(recip_rd);
      end
      if (cmd.div_fix) begin
         q0_in    = q0_calc;
         r0_in    = rem_ff - DUE_W'(q0_calc * DUE_W'(value_rd));
         cprod_in = CPROD_BITS'(count_rd) * CPROD_BITS'(value_rd);
      end
      if (cmd.div_take) begin
         take_in[slot_ff] = use_count ? count_rd : COUNT_BITS'(q_fix);
         rem_in           = use_count ? (rem_ff - DUE_W'(cprod_ff)) : r_fix;
         slot_in          = status.last_slot ? '0 : slot_ff + 1'b1;
      end

      // successful change: whole amount leaves the balance
      if (cmd.commit) begin
         balance_in = balance_ff - BAL_W'(due_ff);
      end

      // per-slot payout result, count deducted as it goes out
      if (cmd.emit_pay) begin
         counts_in[slot_ff] = counts_ff[slot_ff] - take_rd;
         rsp_status_in      = ccd_pkg::STATUS_DONE;
         rsp_slot_in        = slot_ff;
         rsp_count_in       = PAID_W'(take_rd);
         rsp_balance_in     = balance_ff;
         rsp_last_in        = status.last_slot;
         slot_in            = status.last_slot ? '0 : slot_ff + 1'b1;
      end

      // single result: deposit, query or failed change
      if (cmd.emit_single) begin
         rsp_status_in  = cmd.single_fail ? ccd_pkg::STATUS_FAIL : ccd_pkg::STATUS_DONE;
         rsp_slot_in    = '0;
         rsp_count_in   = '0;
         rsp_balance_in = balance_ff;
         rsp_last_in    = 1'b1;
      end
   end

   // Status to the controller
   always_comb begin
      status.last_slot = slot_ff == ccd_pkg::LAST_SLOT;
      status.rem_zero  = rem_ff == '0;
   end

   // Held state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ccd_pkg::NUM_SLOTS; i++) begin
            counts_ff[i] <= '0;
         end
         balance_ff <= '0;
         slot_ff    <= '0;
      end else begin
         counts_ff  <= counts_in;
         balance_ff <= balance_in;
         slot_ff    <= slot_in;
      end
   end

   // Working and result registers
   always_ff @(posedge clock) begin
      take_ff        <= take_in;
      dslot_ff       <= dslot_in;
      amount_ff      <= amount_in;
      due_ff         <= due_in;
      rem_ff         <= rem_in;
      mul_ff         <= mul_in;
      q0_ff          <= q0_in;
      r0_ff          <= r0_in;
      cprod_ff       <= cprod_in;
      dprod_ff       <= dprod_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_balance_ff <= rsp_balance_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_status     = rsp_status_ff;
   assign rsp_paid_slot  = rsp_slot_ff;
   assign rsp_paid_count = rsp_count_ff;
   assign rsp_balance    = rsp_balance_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire

@@ design/ccd_ctrl.sv @@
// ----------------------------------------------------------------------------
// ccd_ctrl: sequencer of the coin change dispenser
// Decodes each request, steps the datapath through deposit, greedy divide
// pass, check and payout, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ccd_ctrl (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire [ccd_pkg::CMD_BITS-1:0]         req_command,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output ccd_pkg::ccd_cmd_type                cmd,
   input  wire ccd_pkg::ccd_status_type        status
);

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_DEP_WRITE = 9'b000000010,
      ST_DEP_ADD   = 9'b000000100,
      ST_DIV_MUL   = 9'b000001000,
      ST_DIV_FIX   = 9'b000010000,
      ST_DIV_TAKE  = 9'b000100000,
      ST_CHECK     = 9'b001000000,
      ST_EMIT      = 9'b010000000,
      ST_SINGLE    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      fail_ff, fail_in;
   logic      out_free;

   // Result register may be loaded when empty or being taken
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      fail_in   = fail_ff;
      cmd       = '0;
      req_stall = state_ff != ST_IDLE;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               fail_in      = 1'b0;
               if (req_command == ccd_pkg::CMD_DEPOSIT) begin
                  state_in = ST_DEP_WRITE;
               end else if (req_command == ccd_pkg::CMD_CHANGE) begin
                  state_in = ST_DIV_MUL;
               end else begin
                  state_in = ST_SINGLE;
               end
            end
         end
         ST_DEP_WRITE: begin
            cmd.dep_write = 1'b1;
            state_in      = ST_DEP_ADD;
         end
         ST_DEP_ADD: begin
            cmd.dep_add = 1'b1;
            state_in    = ST_SINGLE;
         end
         ST_DIV_MUL: begin
            cmd.div_mul = 1'b1;
            state_in    = ST_DIV_FIX;
         end
         ST_DIV_FIX: begin
            cmd.div_fix = 1'b1;
            state_in    = ST_DIV_TAKE;
         end
         ST_DIV_TAKE: begin
            cmd.div_take = 1'b1;
            state_in     = status.last_slot ? ST_CHECK : ST_DIV_MUL;
         end
         ST_CHECK: begin
            if (status.rem_zero) begin
               cmd.commit = 1'b1;
               state_in   = ST_EMIT;
            end else begin
               fail_in  = 1'b1;
               state_in = ST_SINGLE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.emit_pay = 1'b1;
               if (status.last_slot) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SINGLE: begin
            if (out_free) begin
               cmd.emit_single = 1'b1;
               cmd.single_fail = fail_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = (cmd.emit_pay || cmd.emit_single) ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fail_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fail_ff      <= fail_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // A full, stalled result register is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !(cmd.emit_pay || cmd.emit_single))
      else $error("result register overwritten while stalled");

   // A zero remainder leads straight to the payout results
   a_check_pass: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && status.rem_zero) |=> (state_ff == ST_EMIT))
      else $error("successful change did not start payout");

   // Failure flag is only raised by the change check
   a_fail_source: assert property (@(posedge clock) disable iff (reset)
      $rose(fail_ff) |-> $past(state_ff == ST_CHECK))
      else $error("failure flag set outside change check");

   // Payout ends after the last slot goes out
   a_emit_end: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_pay && status.last_slot) |=> (state_ff == ST_IDLE))
      else $error("payout did not end after last slot");

endmodule

`default_nettype wire

@@ design/coin_change_dispenser_top.sv @@
// ----------------------------------------------------------------------------
// coin_change_dispenser_top: coin changer with six limited coin stocks
// Deposit, greedy change and balance query requests; every result carries
// the balance held after its request.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  req_     in         req_valid/req_stall   command, coin_slot, coin_amount, change_due
//  rsp_     out        rsp_valid/rsp_stall   status, paid_slot, paid_count, balance, last
//
//  Deposit: count write, then balance add, then the result; query: straight to the result.
//  Change: multiply, fix and take steps per coin slot in the reciprocal divide loop, a check
//  state, then one payout result per cycle from the result register while it is free to load.
//  Failed change gives its single result after the divide pass and the check.
//  Reset is synchronous and clears all coin counts and the balance.
//  A stalled result holds; the next request is taken while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module coin_change_dispenser_top #(
   parameter int COUNT_BITS = ccd_pkg::COUNT_BITS_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire [ccd_pkg::CMD_BITS-1:0]          req_command,
   input  wire [ccd_pkg::SLOT_BITS-1:0]         req_coin_slot,
   input  wire [ccd_pkg::AMOUNT_BITS-1:0]       req_coin_amount,
   input  wire [ccd_pkg::DUE_BITS-1:0]          req_change_due,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic                                 rsp_status,
   output logic [ccd_pkg::SLOT_BITS-1:0]        rsp_paid_slot,
   output logic [ccd_pkg::PAID_BITS-1:0]        rsp_paid_count,
   output logic [ccd_pkg::BAL_BITS-1:0]         rsp_balance,
   output logic                                 rsp_last
);

   ccd_pkg::ccd_cmd_type    ctrl_cmd;
   ccd_pkg::ccd_status_type dp_status;

   // Sequencer
   ccd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cmd         (ctrl_cmd),
      .status      (dp_status)
   );

   // Counts, balance and divide unit
   ccd_datapath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (ctrl_cmd),
      .status          (dp_status),
      .req_coin_slot   (req_coin_slot),
      .req_coin_amount (req_coin_amount),
      .req_change_due  (req_change_due),
      .rsp_status      (rsp_status),
      .rsp_paid_slot   (rsp_paid_slot),
      .rsp_paid_count  (rsp_paid_count),
      .rsp_balance     (rsp_balance),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire
